>>> hdl/dlmv_pkg.sv
// Shared constants and controller/datapath interface types for the dense
// layer matrix-vector unit. No dependencies.
`timescale 1ns / 1ps

package dlmv_pkg;

  // Field widths of the item, result and configuration channels.
  localparam int OPC_W = 2;
  localparam int ROW_W = 6;
  localparam int COL_W = 7;
  localparam int VAL_W = 16;
  localparam int RES_W = 32;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_INPUTS = 64;
  localparam int DEF_MAX_OUTPUTS = 64;

  // Item opcodes.
  localparam logic [OPC_W-1:0] OP_WR_WEIGHT = 2'd0;
  localparam logic [OPC_W-1:0] OP_WR_INPUT = 2'd1;
  localparam logic [OPC_W-1:0] OP_RUN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic w_we;             // store the incoming weight
    logic x_we;             // store the incoming input element
    logic rd_valid;         // a read/MAC step is issued this cycle
    logic rd_first;         // first step of a row, restarts the accumulator
    logic rd_last;          // bias step, closes the row
    logic [ROW_W-1:0] row_idx;
    logic run_last;         // the current row is the final one of the run
  } dlmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_moved;        // finished row result moved into the output register
  } dlmv_sts_t;

endpackage

>>> hdl/dlmv_ctrl.sv
// Controller for the dense layer unit: configuration registers, item
// decode and the row/column sequencer. Depends on dlmv_pkg.
`timescale 1ns / 1ps

module dlmv_ctrl #(
  parameter int MAX_INPUTS = dlmv_pkg::DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = dlmv_pkg::DEF_MAX_OUTPUTS,
  localparam int STRIDE = MAX_INPUTS + 1,
  localparam int WA_W = $clog2(MAX_OUTPUTS * STRIDE),
  localparam int XA_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int CNT_W = $clog2(MAX_INPUTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dlmv_pkg::OPC_W-1:0]      in_opcode,
  input  logic                            cfg_we,
  input  logic [dlmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlmv_pkg::CFG_W-1:0]      cfg_data,
  input  dlmv_pkg::dlmv_sts_t             sts,
  output dlmv_pkg::dlmv_cmd_t             cmd,
  output logic [WA_W-1:0]                 w_addr,
  output logic [XA_W-1:0]                 x_addr
);
  import dlmv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_ni_r, cfg_no_r;
  logic [CNT_W-1:0] ni_r, ni_nxt, j_r, j_nxt, ni_clamp;
  logic [CFG_W-1:0] no_r, no_nxt, no_clamp;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WA_W-1:0]  base_r, base_nxt;
  logic             accept;
  logic             row_is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ni_r <= CFG_W'(1);
      cfg_no_r <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_INPUTS:  cfg_ni_r <= cfg_data;
        CFG_NUM_OUTPUTS: cfg_no_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one; counts beyond the storage are capped.
  always_comb begin
    if (cfg_ni_r == '0) begin
      ni_clamp = CNT_W'(1);
    end else if (32'(cfg_ni_r) > MAX_INPUTS) begin
      ni_clamp = CNT_W'(MAX_INPUTS);
    end else begin
      ni_clamp = CNT_W'(cfg_ni_r);
    end
    if (cfg_no_r == '0) begin
      no_clamp = CFG_W'(1);
    end else if (32'(cfg_no_r) > MAX_OUTPUTS) begin
      no_clamp = CFG_W'(MAX_OUTPUTS);
    end else begin
      no_clamp = cfg_no_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && (state_r == S_IDLE);
  assign row_is_last = ((CFG_W'(row_r) + CFG_W'(1)) == no_r);

  always_comb begin
    cmd = '0;
    cmd.w_we = accept && (in_opcode == OP_WR_WEIGHT);
    cmd.x_we = accept && (in_opcode == OP_WR_INPUT);
    cmd.rd_valid = (state_r == S_ISSUE);
    cmd.rd_first = (state_r == S_ISSUE) && (j_r == '0);
    cmd.rd_last = (state_r == S_ISSUE) && (j_r == ni_r);
    cmd.row_idx = row_r;
    cmd.run_last = row_is_last;
  end

  // Column ni of a row is its bias, so one running address covers both.
  assign w_addr = base_r + WA_W'(j_r);
  assign x_addr = XA_W'(j_r);

  always_comb begin
    state_nxt = state_r;
    ni_nxt = ni_r;
    no_nxt = no_r;
    j_nxt = j_r;
    row_nxt = row_r;
    base_nxt = base_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == OP_RUN)) begin
          state_nxt = S_ISSUE;
          ni_nxt = ni_clamp;
          no_nxt = no_clamp;
          j_nxt = '0;
          row_nxt = '0;
          base_nxt = '0;
        end
      end
      S_ISSUE: begin
        if (j_r == ni_r) begin
          state_nxt = S_WAIT;
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end
      S_WAIT: begin
        if (sts.res_moved) begin
          if (row_is_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
            j_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
            base_nxt = base_r + WA_W'(STRIDE);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ni_r <= CNT_W'(1);
      no_r <= CFG_W'(1);
      j_r <= '0;
      row_r <= '0;
      base_r <= '0;
    end else begin
      state_r <= state_nxt;
      ni_r <= ni_nxt;
      no_r <= no_nxt;
      j_r <= j_nxt;
      row_r <= row_nxt;
      base_r <= base_nxt;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (j_r <= ni_r))
    else $error("column counter ran past the bias column");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (CFG_W'(row_r) < no_r))
    else $error("row counter ran past the output count");

  a_move_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.res_moved |-> (state_r == S_WAIT))
    else $error("row result moved while the sequencer was not waiting");

endmodule

>>> hdl/dlmv_datapath.sv
// Datapath for the dense layer unit: weight and input memories, the
// multiply-accumulate pipeline and the output register. Depends on dlmv_pkg.
`timescale 1ns / 1ps

module dlmv_datapath #(
  parameter int MAX_INPUTS = dlmv_pkg::DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = dlmv_pkg::DEF_MAX_OUTPUTS,
  localparam int STRIDE = MAX_INPUTS + 1,
  localparam int WDEPTH = MAX_OUTPUTS * STRIDE,
  localparam int WA_W = $clog2(WDEPTH),
  localparam int XA_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dlmv_pkg::ROW_W-1:0]        in_row,
  input  logic [dlmv_pkg::COL_W-1:0]        in_col,
  input  logic signed [dlmv_pkg::VAL_W-1:0] in_value,
  input  dlmv_pkg::dlmv_cmd_t               cmd,
  input  logic [WA_W-1:0]                   w_addr,
  input  logic [XA_W-1:0]                   x_addr,
  output dlmv_pkg::dlmv_sts_t               sts,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [dlmv_pkg::ROW_W-1:0]        out_index,
  output logic signed [dlmv_pkg::RES_W-1:0] out_value,
  output logic                              out_last
);
  import dlmv_pkg::*;

  // Wide enough for every product of a row plus the scaled bias.
  localparam int ACC_W = RES_W + $clog2(MAX_INPUTS + 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

  logic [VAL_W-1:0] wmem [WDEPTH];
  logic [VAL_W-1:0] xmem [MAX_INPUTS];

  logic              w_wr_ok, x_wr_ok;
  logic [WA_W-1:0]   w_wr_addr;
  logic [XA_W-1:0]   x_wr_addr;

  logic signed [VAL_W-1:0] w_q_r, x_q_r;
  logic                    a_valid_r, a_first_r, a_last_r;
  logic signed [RES_W-1:0] prod_r;
  logic                    b_valid_r, b_first_r, b_last_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    hold_r;
  logic                    move;
  logic signed [RES_W-1:0] sat_val;

  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_index_r;
  logic signed [RES_W-1:0] out_value_r;
  logic                    out_last_r;

  assign w_wr_ok = cmd.w_we && (32'(in_row) < MAX_OUTPUTS) && (32'(in_col) <= MAX_INPUTS);
  assign x_wr_ok = cmd.x_we && (32'(in_col) < MAX_INPUTS);
  assign w_wr_addr = WA_W'(32'(in_row) * STRIDE + 32'(in_col));
  assign x_wr_addr = XA_W'(in_col);

  always_ff @(posedge clk) begin
    if (w_wr_ok) begin
      wmem[w_wr_addr] <= in_value;
    end
    w_q_r <= wmem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (x_wr_ok) begin
      xmem[x_wr_addr] <= in_value;
    end
    x_q_r <= xmem[x_addr];
  end

  // Stage B forms one product; the bias step shifts the weight to Q16.16.
  always_ff @(posedge clk) begin
    if (a_last_r) begin
      prod_r <= {{8{w_q_r[VAL_W-1]}}, w_q_r, 8'b0};
    end else begin
      prod_r <= w_q_r * x_q_r;
    end
    if (b_valid_r) begin
      acc_r <= b_first_r ? ACC_W'(prod_r) : (acc_r + ACC_W'(prod_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_first_r <= 1'b0;
      a_last_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_first_r <= 1'b0;
      b_last_r <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      a_valid_r <= cmd.rd_valid;
      a_first_r <= cmd.rd_first;
      a_last_r <= cmd.rd_last;
      b_valid_r <= a_valid_r;
      b_first_r <= a_first_r;
      b_last_r <= a_last_r;
      if (b_valid_r && b_last_r) begin
        hold_r <= 1'b1;
      end else if (move) begin
        hold_r <= 1'b0;
      end
    end
  end

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (acc_r < SAT_LO) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = acc_r[RES_W-1:0];
    end
  end

  // A finished row waits in the accumulator until the output register frees up.
  assign move = hold_r && (!out_valid_r || !out_stall);
  assign sts.res_moved = move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_index_r <= cmd.row_idx;
      out_value_r <= sat_val;
      out_last_r <= cmd.run_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last = out_last_r;

  a_hold_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> (!a_valid_r && !b_valid_r))
    else $error("new row entered the pipeline before the last result left");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_last_r) |-> !hold_r)
    else $error("row result completed while an older one was still held");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("moved result did not appear on the output");

endmodule

>>> hdl/dense_layer_matvec_bias.sv
// Dense layer forward pass (matrix-vector product plus bias), top level.
// Depends on dlmv_pkg, dlmv_ctrl and dlmv_datapath.
//
// Usage: items arrive on the in_ channel (valid/stall). A weight write
// (opcode 0) or input write (opcode 1) is stored in memory, and such items are
// accepted back to back. A run item (opcode 2) computes one result per output
// row, delivered in order on the out_ channel with out_last set on the final
// one. Configuration writes on the cfg_ port set the input count and the output
// count; they are only to be made while the block is idle, which the block
// itself does not enforce. Sequencing: each row issues one memory read per
// input and then one for the bias, passes the multiply stage and the
// accumulate stage, and is handed off to the output register before the next
// row is started; the single MAC unit serves every row, so rows do not overlap.
// While a run is in progress in_stall is high. If the receiver stalls, a
// finished row waits in the accumulator and the next row is not started.
// Reset: control state and both registers (set to one) are cleared; the
// weight and input memories are not, and must be written before use.
`timescale 1ns / 1ps

module dense_layer_matvec_bias #(
  parameter int MAX_INPUTS = dlmv_pkg::DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = dlmv_pkg::DEF_MAX_OUTPUTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dlmv_pkg::OPC_W-1:0]        in_opcode,
  input  logic [dlmv_pkg::ROW_W-1:0]        in_row,
  input  logic [dlmv_pkg::COL_W-1:0]        in_col,
  input  logic signed [dlmv_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dlmv_pkg::ROW_W-1:0]        out_index,
  output logic signed [dlmv_pkg::RES_W-1:0] out_value,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [dlmv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlmv_pkg::CFG_W-1:0]        cfg_data
);
  import dlmv_pkg::*;

  localparam int STRIDE = MAX_INPUTS + 1;
  localparam int WA_W = $clog2(MAX_OUTPUTS * STRIDE);
  localparam int XA_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  dlmv_cmd_t       cmd;
  dlmv_sts_t       sts;
  logic [WA_W-1:0] w_addr;
  logic [XA_W-1:0] x_addr;

  dlmv_ctrl #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_opcode(in_opcode),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sts      (sts),
    .cmd      (cmd),
    .w_addr   (w_addr),
    .x_addr   (x_addr)
  );

  dlmv_datapath #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_value (in_value),
    .cmd      (cmd),
    .w_addr   (w_addr),
    .x_addr   (x_addr),
    .sts      (sts),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_index(out_index),
    .out_value(out_value),
    .out_last (out_last)
  );

endmodule
